FILE: hdl/gbn_pkg.sv
`timescale 1ns / 1ps

package gbn_pkg;

  localparam int PORT_PAYLOAD_W = 64;
  localparam int ACK_W          = 3;
  localparam int SEQ_PORT_W     = 3;
  localparam int CNT_W          = 4;
  localparam int BURST_MAX      = 8;
  localparam int WS_W           = 4;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [WS_W-1:0] WS_RESET        = 4'd4;
  localparam logic            REG_WINDOW_SIZE = 1'b0;

  typedef enum logic [1:0] {
    FUNC_SEND    = 2'd0,
    FUNC_ACK     = 2'd1,
    FUNC_TIMEOUT = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_SENT      = 3'd0,
    ST_REFUSED   = 3'd1,
    ST_ACKED     = 3'd2,
    ST_CORRUPT   = 3'd3,
    ST_DUPLICATE = 3'd4,
    ST_UNKNOWN   = 3'd5,
    ST_EMPTY     = 3'd6,
    ST_TIMEOUT   = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_BURST
  } ctrl_state_t;

  typedef struct packed {
    func_t                     func;
    logic [PORT_PAYLOAD_W-1:0] payload;
    logic [ACK_W-1:0]          ack_number;
    logic                      ack_checksum_ok;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic                      packet_valid;
    logic [SEQ_PORT_W-1:0]     packet_seq;
    logic [PORT_PAYLOAD_W-1:0] packet_payload;
    logic                      timer_start;
    logic                      timer_stop;
    logic [SEQ_PORT_W-1:0]     timer_seq;
    logic                      window_full;
    logic                      last;
  } out_item_t;

endpackage

FILE: hdl/gbn_in_if.sv
`timescale 1ns / 1ps

interface gbn_in_if import gbn_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

FILE: hdl/gbn_out_if.sv
`timescale 1ns / 1ps

interface gbn_out_if import gbn_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

FILE: hdl/gbn_store.sv
`timescale 1ns / 1ps

module gbn_store #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hdl/gbn_apb.sv
`timescale 1ns / 1ps

module gbn_apb import gbn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [WS_W-1:0]       window_size
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_WINDOW_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WS_RESET;
    end else if (wr_en) begin
      window_size <= pwdata[WS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_WINDOW_SIZE: prdata = CFG_DATA_W'(window_size);
      default:         prdata = '0;
    endcase
  end

endmodule

FILE: hdl/gbn_ctrl.sv
`timescale 1ns / 1ps

module gbn_ctrl import gbn_pkg::*; #(
  parameter int SEQ_COUNT    = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  gbn_in_if.sink                       in_ch,
  gbn_out_if.source                    out_ch,
  input  logic [WS_W-1:0]              window_size,
  output logic                         mem_we,
  output logic [$clog2(SEQ_COUNT)-1:0] mem_waddr,
  output logic [PAYLOAD_BITS-1:0]      mem_wdata,
  output logic                         mem_re,
  output logic [$clog2(SEQ_COUNT)-1:0] mem_raddr,
  input  logic [PAYLOAD_BITS-1:0]      mem_rdata
);

  localparam int SW   = $clog2(SEQ_COUNT);
  localparam int SUMW = ((SW > CNT_W) ? SW : CNT_W) + 1;
  localparam int CAP  = (SEQ_COUNT < BURST_MAX) ? SEQ_COUNT : BURST_MAX;
  localparam logic [SW:0]      SC_EXT  = (SW + 1)'(SEQ_COUNT);
  localparam logic [SW-1:0]    SC_LAST = SW'(SEQ_COUNT - 1);
  localparam logic [CNT_W-1:0] CAP_C   = CNT_W'(CAP);

  function automatic logic [SW-1:0] mod_add(input logic [SW-1:0] a,
                                            input logic [CNT_W-1:0] b);
    logic [SUMW-1:0] sum;
    sum = SUMW'(a) + SUMW'(b);
    if (sum >= SUMW'(SEQ_COUNT)) begin
      sum = sum - SUMW'(SEQ_COUNT);
    end
    return SW'(sum);
  endfunction

  ctrl_state_t      state, state_next;
  in_item_t         cmd, cmd_next;
  logic [SW-1:0]    base, base_next;
  logic [SW-1:0]    nseq, nseq_next;
  logic [CNT_W-1:0] outst, outst_next;
  status_t          bstat, bstat_next;
  logic [CNT_W-1:0] bcnt, bcnt_next;
  logic [CNT_W-1:0] idx_rd, idx_rd_next;
  logic [CNT_W-1:0] idx_out, idx_out_next;
  logic             dvalid, dvalid_next;
  logic             out_valid, out_valid_next;
  out_item_t        out_item, out_item_next;

  logic             out_free;
  logic             load;
  logic [WS_W-1:0]  w1;
  logic [CNT_W-1:0] weff;
  logic [SW-1:0]    ack_s;
  logic             ack_ok;
  logic [SW:0]      diff;
  logic [SW-1:0]    ack_gap;
  logic [SW-1:0]    dup_num;

  assign out_free     = !out_valid || out_ch.ready;
  assign load         = (state == S_BURST) && dvalid && out_free;
  assign w1           = (window_size == '0) ? WS_W'(1) : window_size;
  assign weff         = (CNT_W'(w1) > CAP_C) ? CAP_C : CNT_W'(w1);
  assign ack_s        = SW'(cmd.ack_number);
  assign ack_ok       = 32'(cmd.ack_number) < SEQ_COUNT;
  assign diff         = {1'b0, ack_s} + SC_EXT - {1'b0, base};
  assign ack_gap      = (diff >= SC_EXT) ? SW'(diff - SC_EXT) : SW'(diff);
  assign dup_num      = (base == '0) ? SC_LAST : base - 1'b1;
  assign in_ch.ready  = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.item  = out_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      base      <= '0;
      nseq      <= '0;
      outst     <= '0;
      dvalid    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      base      <= base_next;
      nseq      <= nseq_next;
      outst     <= outst_next;
      dvalid    <= dvalid_next;
      out_valid <= out_valid_next;
    end
    cmd      <= cmd_next;
    bstat    <= bstat_next;
    bcnt     <= bcnt_next;
    idx_rd   <= idx_rd_next;
    idx_out  <= idx_out_next;
    out_item <= out_item_next;
  end

  always_comb begin
    state_next     = state;
    cmd_next       = cmd;
    base_next      = base;
    nseq_next      = nseq;
    outst_next     = outst;
    bstat_next     = bstat;
    bcnt_next      = bcnt;
    idx_rd_next    = idx_rd;
    idx_out_next   = idx_out;
    dvalid_next    = dvalid;
    out_valid_next = out_valid && !out_ch.ready;
    out_item_next  = out_item;
    mem_we         = 1'b0;
    mem_waddr      = nseq;
    mem_wdata      = cmd.payload[PAYLOAD_BITS-1:0];
    mem_re         = 1'b0;
    mem_raddr      = mod_add(base, idx_rd);

    unique case (state)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_next   = in_ch.item;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          out_item_next      = '0;
          out_item_next.last = 1'b1;
          state_next         = S_IDLE;
          case (cmd.func)
            FUNC_SEND: begin
              out_valid_next = 1'b1;
              if (outst >= weff) begin
                out_item_next.status = ST_REFUSED;
              end else begin
                mem_we                       = 1'b1;
                out_item_next.status         = ST_SENT;
                out_item_next.packet_valid   = 1'b1;
                out_item_next.packet_seq     = SEQ_PORT_W'(nseq);
                out_item_next.packet_payload = PORT_PAYLOAD_W'(mem_wdata);
                out_item_next.timer_start    = (outst == '0);
                outst_next                   = outst + 1'b1;
                nseq_next                    = mod_add(nseq, CNT_W'(1));
              end
            end
            FUNC_ACK: begin
              if (outst == '0) begin
                out_valid_next       = 1'b1;
                out_item_next.status = ST_EMPTY;
              end else if (ack_ok && (SUMW'(ack_gap) < SUMW'(outst))) begin
                if (cmd.ack_checksum_ok) begin
                  out_valid_next            = 1'b1;
                  out_item_next.status      = ST_ACKED;
                  outst_next                = outst - CNT_W'(ack_gap) - 1'b1;
                  base_next                 = mod_add(ack_s, CNT_W'(1));
                  out_item_next.timer_start = (outst_next != '0);
                  out_item_next.timer_stop  = 1'b1;
                end else begin
                  bstat_next = ST_CORRUPT;
                  state_next = S_BURST;
                end
              end else if (ack_ok && (ack_s == dup_num)) begin
                out_valid_next       = 1'b1;
                out_item_next.status = ST_DUPLICATE;
              end else begin
                bstat_next = ST_UNKNOWN;
                state_next = S_BURST;
              end
            end
            FUNC_TIMEOUT: begin
              if (outst == '0) begin
                out_valid_next           = 1'b1;
                out_item_next.status     = ST_TIMEOUT;
                out_item_next.timer_stop = 1'b1;
              end else begin
                bstat_next = ST_TIMEOUT;
                state_next = S_BURST;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
          out_item_next.timer_seq   = SEQ_PORT_W'(base_next);
          out_item_next.window_full = (outst_next >= weff);
          bcnt_next                 = outst;
          idx_rd_next               = '0;
          idx_out_next              = '0;
          dvalid_next               = 1'b0;
        end
      end

      S_BURST: begin
        mem_re = (idx_rd < bcnt) && (!dvalid || load);
        if (mem_re) begin
          idx_rd_next = idx_rd + 1'b1;
        end
        dvalid_next = mem_re || (dvalid && !load);
        if (load) begin
          out_valid_next               = 1'b1;
          out_item_next.status         = bstat;
          out_item_next.packet_valid   = 1'b1;
          out_item_next.packet_seq     = SEQ_PORT_W'(mod_add(base, idx_out));
          out_item_next.packet_payload = PORT_PAYLOAD_W'(mem_rdata);
          out_item_next.timer_start    = (idx_out == '0);
          out_item_next.timer_stop     = (idx_out == '0);
          out_item_next.timer_seq      = SEQ_PORT_W'(base);
          out_item_next.window_full    = (outst >= weff);
          out_item_next.last           = (idx_out == bcnt - 1'b1);
          idx_out_next                 = idx_out + 1'b1;
          if (idx_out == bcnt - 1'b1) begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_seq_consistent: assert property (@(posedge clk) disable iff (rst)
    mod_add(base, outst) == nseq)
    else $error("Next sequence number disagrees with base and outstanding count.");

  a_outst_cap: assert property (@(posedge clk) disable iff (rst)
    outst <= CAP_C)
    else $error("Outstanding count exceeds the window limit.");

  a_read_lead: assert property (@(posedge clk) disable iff (rst)
    (state == S_BURST) |-> (idx_rd == idx_out + CNT_W'(dvalid)))
    else $error("Resend read pointer out of step with delivered packets.");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (load && (idx_out == bcnt - 1'b1)) |=> (state == S_IDLE))
    else $error("Sequencer did not return to idle after the final packet.");

  a_no_write_burst: assert property (@(posedge clk) disable iff (rst)
    (state == S_BURST) |-> !mem_we)
    else $error("Payload memory written during a resend burst.");

endmodule

FILE: hdl/go_back_n_sender_unit.sv
`timescale 1ns / 1ps

// Channel   Role        Handshake          Carries
// in_ch     item in     valid / ready      func, payload, ack_number, ack_checksum_ok
// out_ch    result out  valid / ready      status, packet, timer requests, window_full, last
// APB       config      psel / penable     window_size at byte address 0
//
// An item with one result is registered in S_IDLE; S_EXEC then decides it and updates the window
// and the payload memory.
// A resend of n packets is registered, decided, then read from memory one packet ahead of output.
// Reset is synchronous; the payload memory is not cleared.
// A stalled result holds the sequencer; a new item is taken whenever it is idle.

module go_back_n_sender_unit import gbn_pkg::*; #(
  parameter int SEQ_COUNT    = 8,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  gbn_in_if.sink                in_ch,
  gbn_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int SW = $clog2(SEQ_COUNT);

  logic [WS_W-1:0]         window_size;
  logic                    mem_we;
  logic [SW-1:0]           mem_waddr;
  logic [PAYLOAD_BITS-1:0] mem_wdata;
  logic                    mem_re;
  logic [SW-1:0]           mem_raddr;
  logic [PAYLOAD_BITS-1:0] mem_rdata;

  gbn_apb u_apb (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .window_size (window_size)
  );

  gbn_store #(
    .DEPTH (SEQ_COUNT),
    .WIDTH (PAYLOAD_BITS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  gbn_ctrl #(
    .SEQ_COUNT    (SEQ_COUNT),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .window_size (window_size),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

endmodule
